// ----- rtl/matrix_keypad_scanner_core_defines.svh -----
// Assertion macros for the keypad scanner core.
`ifndef MATRIX_KEYPAD_SCANNER_CORE_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");
// Next-cycle implication
`define KPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");
`else
`define KPS_ASSERT_IMPL(label, ante, cons)
`define KPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/kps_pkg.sv -----
// Shared types, constants and helpers of the keypad scanner.
package kps_pkg;

  // Parameter defaults
  localparam int ROW_COUNT_DEF    = 5;
  localparam int COLUMN_COUNT_DEF = 5;

  // Fixed field geometry
  localparam int SAMPLE_W     = 5;
  localparam int SAMPLE_COLS  = 5;
  localparam int PER_COL_W    = SAMPLE_W * SAMPLE_COLS;
  localparam logic [SAMPLE_W-1:0] ALL_HIGH = '1;

  // Register reset values and indexes
  localparam logic [7:0] FIRST_DELAY_RST = 8'd50;
  localparam logic [7:0] PERIOD_RST      = 8'd10;
  localparam logic       REG_FIRST_DELAY = 1'b0;
  localparam logic       REG_PERIOD      = 1'b1;

  // Event codes
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_REPEAT  = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // One result item
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [2:0] row;
    logic [2:0] column;
    logic [4:0] index;
  } kps_event_t;

  // Row of the single low bit; one_low is clear when not exactly one is low
  function automatic logic [3:0] single_low_row(input logic [SAMPLE_W-1:0] pat);
    logic [SAMPLE_W-1:0] inv;
    logic [2:0]          row;
    inv = ~pat;
    row = 3'd0;
    for (int r = SAMPLE_W - 1; r >= 0; r--) begin
      if (inv[r]) row = 3'(r);
    end
    single_low_row = {$onehot(inv), row};
  endfunction

endpackage

// ----- rtl/kps_cfg_regs.sv -----
// APB register block holding the auto-repeat timing.
module kps_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  repeat_first_delay,
  output logic [7:0]  repeat_period
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_first_delay <= kps_pkg::FIRST_DELAY_RST;
      repeat_period      <= kps_pkg::PERIOD_RST;
    end else if (wr_en) begin
      if (paddr[2] == kps_pkg::REG_FIRST_DELAY) repeat_first_delay <= pwdata[7:0];
      if (paddr[2] == kps_pkg::REG_PERIOD)      repeat_period      <= pwdata[7:0];
    end
  end

  // Read mux
  assign prdata = (paddr[2] == kps_pkg::REG_PERIOD) ? {24'd0, repeat_period}
                                                    : {24'd0, repeat_first_delay};

endmodule

// ----- rtl/kps_scan_fsm.sv -----
// Scan phase machine: key detect, confirm, auto-repeat and release.
module kps_scan_fsm #(
  parameter int ROW_COUNT    = kps_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = kps_pkg::COLUMN_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [kps_pkg::SAMPLE_W-1:0]  rows_all,
  input  logic [kps_pkg::PER_COL_W-1:0] rows_cols,
  input  logic [7:0]                    repeat_first_delay,
  input  logic [7:0]                    repeat_period,
  output kps_pkg::kps_event_t           ev
);

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2,
    PH_START   = 2'd3
  } phase_t;

  // Rows past ROW_COUNT read as released
  localparam logic [4:0] ROW_UNUSED =
    (ROW_COUNT >= 5) ? 5'd0 : 5'(~((32'd1 << ROW_COUNT) - 32'd1));
  localparam logic [3:0] COLS = 4'(COLUMN_COUNT);

  phase_t     phase, phase_next;
  logic [4:0] held_pattern, held_pattern_next;
  logic [2:0] held_column, held_column_next;
  logic [7:0] repeat_count, repeat_count_next;
  logic [4:0] held_key, held_key_next;

  logic [4:0] all_n;
  logic [4:0] samp [kps_pkg::SAMPLE_COLS];
  logic       found;
  logic [2:0] found_col;
  logic [4:0] found_pat;
  logic [4:0] cur_samp;
  logic [3:0] cur_row;
  logic [3:0] held_row;
  logic [7:0] new_key;
  logic [7:0] cnt_dec;

  // Normalized samples per driven column
  always_comb begin
    all_n = rows_all | ROW_UNUSED;
    for (int c = 0; c < kps_pkg::SAMPLE_COLS; c++) begin
      samp[c] = rows_cols[kps_pkg::SAMPLE_W*c +: kps_pkg::SAMPLE_W] | ROW_UNUSED;
    end
  end

  // First column showing a low row
  always_comb begin
    found     = 1'b0;
    found_col = 3'd0;
    found_pat = kps_pkg::ALL_HIGH;
    for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
      if (c < kps_pkg::SAMPLE_COLS && samp[c] != kps_pkg::ALL_HIGH) begin
        found     = 1'b1;
        found_col = 3'(c);
        found_pat = samp[c];
      end
    end
  end

  // Sample of the latched column, its low row and the key number
  assign cur_samp = (held_column < 3'(kps_pkg::SAMPLE_COLS)) ? samp[held_column]
                                                             : kps_pkg::ALL_HIGH;
  assign cur_row  = kps_pkg::single_low_row(cur_samp);
  assign held_row = kps_pkg::single_low_row(held_pattern);
  assign new_key  = 8'(cur_row[2:0]) * 8'(COLS) + 8'(held_column);
  assign cnt_dec  = (repeat_count != 8'd0) ? repeat_count - 8'd1 : 8'd0;

  // Next state and event
  always_comb begin
    phase_next        = phase;
    held_pattern_next = held_pattern;
    held_column_next  = held_column;
    repeat_count_next = repeat_count;
    held_key_next     = held_key;
    ev.valid  = 1'b0;
    ev.kind   = kps_pkg::EV_PRESS;
    ev.row    = held_row[2:0];
    ev.column = held_column;
    ev.index  = held_key;
    case (phase)
      PH_READY: begin
        if (all_n != kps_pkg::ALL_HIGH) begin
          if (found) begin
            held_pattern_next = found_pat;
            held_column_next  = found_col;
            phase_next        = PH_CONFIRM;
          end else begin
            phase_next = PH_START;
          end
        end
      end
      PH_CONFIRM: begin
        if (cur_samp == held_pattern && cur_row[3]) begin
          held_key_next     = new_key[4:0];
          repeat_count_next = repeat_first_delay;
          phase_next        = PH_HELD;
          ev.valid          = 1'b1;
          ev.kind           = kps_pkg::EV_PRESS;
          ev.index          = new_key[4:0];
        end else begin
          phase_next = PH_START;
        end
      end
      PH_HELD: begin
        if (cur_samp == held_pattern) begin
          if (cnt_dec == 8'd0) begin
            repeat_count_next = repeat_period;
            ev.valid          = 1'b1;
            ev.kind           = kps_pkg::EV_REPEAT;
          end else begin
            repeat_count_next = cnt_dec;
          end
        end else begin
          phase_next = PH_START;
          ev.valid   = 1'b1;
          ev.kind    = kps_pkg::EV_RELEASE;
        end
      end
      default: begin
        phase_next = PH_READY;
      end
    endcase
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      held_pattern <= kps_pkg::ALL_HIGH;
      held_column  <= 3'd0;
      repeat_count <= 8'd0;
      held_key     <= 5'd0;
    end else if (go) begin
      phase        <= phase_next;
      held_pattern <= held_pattern_next;
      held_column  <= held_column_next;
      repeat_count <= repeat_count_next;
      held_key     <= held_key_next;
    end
  end

endmodule

// ----- rtl/matrix_keypad_scanner_core.sv -----
// Keypad scanner core: one poll tick per item in, zero or one key event out.
// Each accepted item is one poll tick; it is registered, run through the
// scan phase machine when the output register is free or being emptied, and any
// press, auto-repeat or release event is held in an output register. One item
// is taken every clock cycle while the input is not stalled; an event passes
// through the input register and the output register before it is presented. The input
// stalls only while the output register holds an event that is itself stalled.
// Timing registers (APB, byte address 0: first repeat delay, 4: repeat period)
// count in poll ticks and should be changed only while no tick is in flight.
`include "matrix_keypad_scanner_core_defines.svh"
module matrix_keypad_scanner_core #(
  parameter int ROW_COUNT    = kps_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = kps_pkg::COLUMN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // poll tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  rows_all_driven,
  input  logic [24:0] rows_per_column,
  // key events
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [2:0]  key_row,
  output logic [2:0]  key_column,
  output logic [4:0]  key_index,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        s1_valid;
  logic [4:0]  s1_all;
  logic [24:0] s1_cols;
  logic        accept;
  logic        advance;
  logic [7:0]  repeat_first_delay;
  logic [7:0]  repeat_period;
  kps_pkg::kps_event_t ev;

  kps_cfg_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .repeat_first_delay (repeat_first_delay),
    .repeat_period      (repeat_period)
  );

  // Handshake: process when the output register is free or being emptied
  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_all  <= rows_all_driven;
      s1_cols <= rows_per_column;
    end
  end

  kps_scan_fsm #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_fsm (
    .clk                (clk),
    .rst                (rst),
    .go                 (advance),
    .rows_all           (s1_all),
    .rows_cols          (s1_cols),
    .repeat_first_delay (repeat_first_delay),
    .repeat_period      (repeat_period),
    .ev                 (ev)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ev.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && ev.valid) begin
      event_kind <= ev.kind;
      key_row    <= ev.row;
      key_column <= ev.column;
      key_index  <= ev.index;
    end
  end

  // Checks
  `KPS_ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid)
  `KPS_ASSERT_IMPL(a_event_from_item, $rose(out_valid), $past(s1_valid))
  `KPS_ASSERT_IMPL(a_event_in_matrix, out_valid, (int'(key_row) < ROW_COUNT) && (int'(key_column) < COLUMN_COUNT))
  `KPS_ASSERT_IMPL(a_event_code, out_valid, event_kind == kps_pkg::EV_PRESS || event_kind == kps_pkg::EV_REPEAT || event_kind == kps_pkg::EV_RELEASE)

endmodule
